// File: sv/windowed_duplicate_detector_macros.svh
// Assertion macros used by the windowed duplicate detector top level.
// The macros expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef WINDOWED_DUPLICATE_DETECTOR_MACROS_SVH
`define WINDOWED_DUPLICATE_DETECTOR_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define WDD_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("wdd assertion failed: invariant");

// A trigger that must be followed by a consequence in the next cycle.
`define WDD_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("wdd assertion failed: next-cycle check");

`endif

// File: sv/wdd_pkg.sv
// Package of the windowed duplicate detector: sizes, register codes and cell types.
// It depends on nothing; the cell, cfg and top-level files take names from it by scope.
package wdd_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int VALUE_W    = 32;
  localparam int WINDOW_W   = 7;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  typedef enum logic {
    REG_WINDOW = 1'b0
  } reg_idx_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               valid;
  } cell_data_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

// File: sv/wdd_cell.sv
// One history cell of the duplicate detector chain: a held value and its valid bit.
// It depends on wdd_pkg for the cell data and control types.
module wdd_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  wdd_pkg::cell_ctl_t        ctl,
  input  wdd_pkg::cell_data_t       prev,
  input  logic [wdd_pkg::VALUE_W-1:0] key,
  input  logic                      in_window,
  output wdd_pkg::cell_data_t       held,
  output logic                      match
);

  logic [wdd_pkg::VALUE_W-1:0] value_r;
  logic                        valid_r;
  logic                        valid_nxt;

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctl.shift) begin
      valid_nxt = prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift && !ctl.clear) begin
      value_r <= prev.value;
    end
  end

  assign held.value = value_r;
  assign held.valid = valid_r;
  assign match      = valid_r && in_window && (value_r == key);

endmodule

// File: sv/wdd_cfg.sv
// Configuration register block of the duplicate detector: the saturating window register.
// It depends on wdd_pkg for widths and the register index codes.
module wdd_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wdd_pkg::ADDR_W-1:0]   paddr,
  input  logic [wdd_pkg::DATA_W-1:0]   pwdata,
  output logic [wdd_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output logic [wdd_pkg::WINDOW_W-1:0] window
);

  logic [wdd_pkg::WINDOW_W-1:0] window_r;
  logic [wdd_pkg::WINDOW_W-1:0] window_nxt;
  logic [wdd_pkg::WINDOW_W-1:0] wr_val;
  wdd_pkg::reg_idx_t            reg_idx;
  logic                         wr_en;

  assign reg_idx = wdd_pkg::reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign wr_val  = pwdata[wdd_pkg::WINDOW_W-1:0];

  always_comb begin
    window_nxt = window_r;
    if (wr_en) begin
      case (reg_idx)
        wdd_pkg::REG_WINDOW: begin
          if (int'(wr_val) > wdd_pkg::WINDOW_MAX) begin
            window_nxt = wdd_pkg::WINDOW_W'(wdd_pkg::WINDOW_MAX);
          end else begin
            window_nxt = wr_val;
          end
        end
        default: begin
          window_nxt = window_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else begin
      window_r <= window_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      wdd_pkg::REG_WINDOW: begin
        prdata = {{(wdd_pkg::DATA_W-wdd_pkg::WINDOW_W){1'b0}}, window_r};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  assign pready = 1'b1;
  assign window = window_r;

endmodule

// File: sv/windowed_duplicate_detector.sv
// Top level of the windowed duplicate detector: cell chain, match reduction and output stage.
// It depends on wdd_pkg, wdd_cell, wdd_cfg and windowed_duplicate_detector_macros.svh.
//
//   Channel   Direction  Handshake            Payload
//   in        input      in_valid/in_ready    in_value, in_end_of_set
//   out       output     out_valid/out_ready  out_dup_here, out_dup_any, out_end_marker
//   cfg       input      psel/penable/pready  paddr, pwdata, prdata
//
// One item is accepted per cycle while in_ready is high; its result passes the match and output registers.
// The rate is set by the row of WINDOW_MAX cells that all compare the new value in parallel.
// The per-cell matches are registered, then reduced and merged into the sticky flag.
// Reset is synchronous and clears the valid bits, the sticky flag and the window register.
// A stalled output holds its result while one more item waits in the match stage.
`include "windowed_duplicate_detector_macros.svh"

module windowed_duplicate_detector (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [wdd_pkg::VALUE_W-1:0] in_value,
  input  logic                         in_end_of_set,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_dup_here,
  output logic                         out_dup_any,
  output logic                         out_end_marker,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wdd_pkg::ADDR_W-1:0]   paddr,
  input  logic [wdd_pkg::DATA_W-1:0]   pwdata,
  output logic [wdd_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  logic [wdd_pkg::WINDOW_W-1:0]   window;
  wdd_pkg::cell_ctl_t             ctl;
  wdd_pkg::cell_data_t            chain [wdd_pkg::WINDOW_MAX+1];
  logic [wdd_pkg::WINDOW_MAX-1:0] in_win;
  logic [wdd_pkg::WINDOW_MAX-1:0] match;
  logic                           in_xfer;
  logic                           out_adv;

  logic [wdd_pkg::WINDOW_MAX-1:0] match_r;
  logic                           s1_last_r;
  logic                           s1_valid_r;
  logic                           s1_valid_nxt;
  logic                           hit;
  logic                           found_r;
  logic                           found_nxt;
  logic                           out_valid_r;
  logic                           out_valid_nxt;
  logic                           dup_here_r;
  logic                           dup_any_r;
  logic                           end_marker_r;

  wdd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .window  (window)
  );

  assign out_adv  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || out_adv;
  assign in_xfer  = in_valid && in_ready;

  assign ctl.shift = in_xfer;
  assign ctl.clear = in_xfer && in_end_of_set;

  assign chain[0].value = in_value;
  assign chain[0].valid = 1'b1;

  for (genvar d = 0; d < wdd_pkg::WINDOW_MAX; d++) begin : g_cell
    assign in_win[d] = int'(window) > d;

    wdd_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .prev      (chain[d]),
      .key       (in_value),
      .in_window (in_win[d]),
      .held      (chain[d+1]),
      .match     (match[d])
    );
  end

  assign s1_valid_nxt = in_ready ? in_xfer : s1_valid_r;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      match_r   <= match;
      s1_last_r <= in_end_of_set;
    end
  end

  assign hit = |match_r;

  always_comb begin
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;
    if (out_adv) begin
      out_valid_nxt = s1_valid_r;
      if (s1_valid_r) begin
        found_nxt = s1_last_r ? 1'b0 : (found_r || hit);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      dup_here_r   <= hit;
      dup_any_r    <= found_r || hit;
      end_marker_r <= s1_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_dup_here   = dup_here_r;
  assign out_dup_any    = dup_any_r;
  assign out_end_marker = end_marker_r;

  `WDD_ASSERT_ALWAYS(a_here_implies_any, !out_valid || !out_dup_here || out_dup_any)
  `WDD_ASSERT_ALWAYS(a_window_in_range, int'(window) <= wdd_pkg::WINDOW_MAX)
  `WDD_ASSERT_NEXT(a_end_clears_head, in_xfer && in_end_of_set, !chain[1].valid)
  `WDD_ASSERT_NEXT(a_end_clears_flag, out_adv && s1_valid_r && s1_last_r, !found_r)
  `WDD_ASSERT_NEXT(a_head_loaded, in_xfer && !in_end_of_set,
                   chain[1].valid && chain[1].value == $past(in_value))
  `WDD_ASSERT_NEXT(a_stage_holds, s1_valid_r && !out_adv,
                   s1_valid_r && $stable(match_r) && $stable(s1_last_r))

endmodule
